[src/fqs_pkg.sv]
`timescale 1ns / 1ps

package fqs_pkg;

    localparam int DEPTH  = 16;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int POS_W  = 5;
    localparam int OP_W   = 2;
    localparam int ST_W   = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_SEARCH  = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef struct packed {
        logic    enq;
        logic    deq;
        logic    scan_init;
        logic    scan_en;
        logic    res_load;
        t_status res_status;
        logic    res_found;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic hit;
        logic last;
        logic out_free;
    } t_sts;

endpackage

[src/fqs_ctrl.sv]
`timescale 1ns / 1ps

module fqs_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [fqs_pkg::OP_W-1:0]  i_op,
    output logic                      o_ready,
    input  fqs_pkg::t_sts             i_sts,
    output fqs_pkg::t_cmd             o_cmd
);
    import fqs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_WAIT = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   accept;
    logic   done;

    assign o_ready = (r_state == S_IDLE) && i_sts.out_free;
    assign accept  = o_ready && i_valid;
    assign done    = i_sts.hit || i_sts.last;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.res_status = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (t_op'(i_op))
                        OP_ENQUEUE: begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.enq        = !i_sts.full;
                            o_cmd.res_status = i_sts.full ? ST_OVERFLOW : ST_OK;
                        end
                        OP_DEQUEUE: begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.deq        = !i_sts.empty;
                            o_cmd.res_status = i_sts.empty ? ST_UNDERFLOW : ST_OK;
                        end
                        OP_SEARCH: begin
                            if (i_sts.empty) begin
                                o_cmd.res_load   = 1'b1;
                                o_cmd.res_status = ST_UNDERFLOW;
                            end else begin
                                o_cmd.scan_init = 1'b1;
                                n_state         = S_SCAN;
                            end
                        end
                        default: begin
                            o_cmd.res_load = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (done) begin
                    if (i_sts.out_free) begin
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_found  = i_sts.hit;
                        o_cmd.res_status = i_sts.hit ? ST_OK : ST_NOT_FOUND;
                        n_state          = S_IDLE;
                    end else begin
                        n_state = S_WAIT;
                    end
                end else begin
                    o_cmd.scan_en = 1'b1;
                end
            end
            S_WAIT: begin
                if (i_sts.out_free) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_found  = i_sts.hit;
                    o_cmd.res_status = i_sts.hit ? ST_OK : ST_NOT_FOUND;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[src/fqs_dp.sv]
`timescale 1ns / 1ps

module fqs_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [fqs_pkg::DATA_W-1:0]  i_value,
    input  fqs_pkg::t_cmd               i_cmd,
    output fqs_pkg::t_sts               o_sts,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [fqs_pkg::ST_W-1:0]    o_status,
    output logic [fqs_pkg::POS_W-1:0]   o_position
);
    import fqs_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];

    logic [ADDR_W-1:0] r_head, r_tail, r_ptr;
    logic [CNT_W-1:0]  r_occ;
    logic [CNT_W-1:0]  r_cmp_cnt;
    logic              r_cmp_vld;
    logic [DATA_W-1:0] r_key;
    logic [DATA_W-1:0] r_rd_data;
    logic              r_m_valid;
    logic [ST_W-1:0]   r_status;
    logic [POS_W-1:0]  r_position;
    logic [CNT_W:0]    pos_full;

    function automatic logic [ADDR_W-1:0] ring_next(input logic [ADDR_W-1:0] idx);
        ring_next = (idx == ADDR_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    assign pos_full = {1'b0, r_cmp_cnt} + 1'b1;

    assign o_sts.full     = (r_occ == CNT_W'(DEPTH));
    assign o_sts.empty    = (r_occ == '0);
    assign o_sts.hit      = r_cmp_vld && (r_rd_data == r_key);
    assign o_sts.last     = r_cmp_vld && (pos_full == {1'b0, r_occ});
    assign o_sts.out_free = !r_m_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.enq) begin
            mem[r_tail] <= i_value;
        end
        if (i_cmd.scan_en) begin
            r_rd_data <= mem[r_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_tail    <= '0;
            r_occ     <= '0;
            r_cmp_vld <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cmd.enq) begin
                r_tail <= ring_next(r_tail);
                r_occ  <= r_occ + 1'b1;
            end
            if (i_cmd.deq) begin
                r_head <= ring_next(r_head);
                r_occ  <= r_occ - 1'b1;
            end
            if (i_cmd.scan_init) begin
                r_cmp_vld <= 1'b0;
            end else if (i_cmd.scan_en) begin
                r_cmp_vld <= 1'b1;
            end
            if (i_cmd.res_load) begin
                r_m_valid <= 1'b1;
            end else if (i_ready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_ptr     <= r_head;
            r_cmp_cnt <= '0;
            r_key     <= i_value;
        end else if (i_cmd.scan_en) begin
            r_ptr <= ring_next(r_ptr);
            if (r_cmp_vld) begin
                r_cmp_cnt <= r_cmp_cnt + 1'b1;
            end
        end
        if (i_cmd.res_load) begin
            r_status   <= i_cmd.res_status;
            r_position <= i_cmd.res_found ? POS_W'(pos_full) : '0;
        end
    end

    assign o_valid    = r_m_valid;
    assign o_status   = r_status;
    assign o_position = r_position;

endmodule

[src/fifo_queue_with_search_unit.sv]
`timescale 1ns / 1ps
// Enqueue, dequeue and search on an empty queue: result registered in the cycle after the
// transaction. Search scans one stored entry per cycle from the front through the single
// memory read port and stops at the first match or at the last stored entry.
// One item in flight at a time; the next transaction is taken in the cycle the previous result
// leaves, so enqueue and dequeue sustain one per cycle while the output is ready.
// Synchronous active-low reset empties the queue; stored words are not cleared.
module fifo_queue_with_search_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic [1:0]  s_axis_tuser,   // [1:0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [4:0] position, [7:5] zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);
    import fqs_pkg::*;

    t_cmd             cmd;
    t_sts             sts;
    logic [POS_W-1:0] position;

    fqs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_op    (s_axis_tuser),
        .o_ready (s_axis_tready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    fqs_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_value    (s_axis_tdata),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_status   (m_axis_tuser),
        .o_position (position)
    );

    assign m_axis_tdata = {{(8 - POS_W){1'b0}}, position};

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import fqs_pkg::*;

    typedef struct {
        t_status           status;
        logic [POS_W-1:0]  position;
    } t_answer;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [31:0]       s_axis_tdata  = '0;   // [31:0] value
    logic [1:0]        s_axis_tuser  = '0;   // [1:0] operation
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [7:0]        m_axis_tdata;         // [4:0] position, [7:5] zero
    logic [1:0]        m_axis_tuser;         // [1:0] status

    // queue shadow
    logic [DATA_W-1:0] q_words [DEPTH];
    logic [ADDR_W-1:0] q_head  = '0;
    logic [ADDR_W-1:0] q_tail  = '0;
    logic [CNT_W-1:0]  q_count = '0;

    t_answer           pending_answers [$];
    t_answer           want;
    t_answer           got;

    int  fail_count     = 0;
    int  results_seen   = 0;
    int  op_tally [4]   = '{0, 0, 0, 0};
    int  search_hits    = 0;
    int  search_misses  = 0;
    int  overflows      = 0;
    int  underflows     = 0;

    // sender burst state
    int  burst_left     = 0;
    bit  valid_dropped  = 1'b1;

    // receiver state
    bit  hold_off_req   = 1'b0;
    int  hold_left      = 0;
    int  rx_mode        = 0;
    int  rx_mode_left   = 0;

    fifo_queue_with_search_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #4_800_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [ADDR_W-1:0] ring_advance(input logic [ADDR_W-1:0] idx);
        return (int'(idx) == DEPTH - 1) ? '0 : idx + 1'b1;
    endfunction

    function automatic t_answer predict_queue_op(input t_op op, input logic [DATA_W-1:0] word);
        t_answer           ans;
        logic [ADDR_W-1:0] idx;
        bit                found;
        ans.status   = ST_OK;
        ans.position = '0;
        found        = 1'b0;
        case (op)
            OP_ENQUEUE: begin
                if (int'(q_count) >= DEPTH) begin
                    ans.status = ST_OVERFLOW;
                end else begin
                    q_words[q_tail] = word;
                    q_tail          = ring_advance(q_tail);
                    q_count         = q_count + 1'b1;
                end
            end
            OP_DEQUEUE: begin
                if (q_count == 0) begin
                    ans.status = ST_UNDERFLOW;
                end else begin
                    q_head  = ring_advance(q_head);
                    q_count = q_count - 1'b1;
                end
            end
            OP_SEARCH: begin
                if (q_count == 0) begin
                    ans.status = ST_UNDERFLOW;
                end else begin
                    idx = q_head;
                    for (int k = 0; k < int'(q_count); k++) begin
                        if (!found && q_words[idx] == word) begin
                            ans.position = POS_W'(k + 1);
                            found        = 1'b1;
                        end
                        idx = ring_advance(idx);
                    end
                    if (!found) begin
                        ans.status = ST_NOT_FOUND;
                    end
                end
            end
            default: begin
            end
        endcase
        return ans;
    endfunction

    // result checker and input tap
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.status   = t_status'(m_axis_tuser);
                got.position = m_axis_tdata[POS_W-1:0];
                if (pending_answers.size() == 0) begin
                    $error("unexpected result: status %0d position %0d",
                           got.status, got.position);
                    fail_count++;
                end else begin
                    want = pending_answers.pop_front();
                    results_seen++;
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, got.status);
                        fail_count++;
                    end
                    if (got.position !== want.position) begin
                        $error("position: expected %0d, actual %0d",
                               want.position, got.position);
                        fail_count++;
                    end
                    if (m_axis_tdata[7:POS_W] !== '0) begin
                        $error("tdata pad: expected 0, actual %0d", m_axis_tdata[7:POS_W]);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                want = predict_queue_op(t_op'(s_axis_tuser), s_axis_tdata);
                pending_answers.push_back(want);
                op_tally[s_axis_tuser]++;
                if (t_op'(s_axis_tuser) == OP_SEARCH && want.status == ST_OK) search_hits++;
                if (want.status == ST_NOT_FOUND) search_misses++;
                if (want.status == ST_OVERFLOW) overflows++;
                if (want.status == ST_UNDERFLOW) underflows++;
            end
        end
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        if (hold_off_req) begin
            hold_off_req = 1'b0;
            hold_left    = 150;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(20, 200);
            end
            rx_mode_left--;
            case (rx_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= ($urandom_range(0, 1) == 0);
                2:       m_axis_tready <= ($urandom_range(0, 3) != 0);
                default: m_axis_tready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    task automatic send_item(input t_op op, input logic [DATA_W-1:0] word,
                             input bit keep_streaming);
        int gap;
        s_axis_tuser  <= op;
        s_axis_tdata  <= word;
        s_axis_tvalid <= 1'b1;
        valid_dropped  = 1'b0;
        do @(posedge i_clk); while (!s_axis_tready);
        if (!keep_streaming) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20)
                                                  : $urandom_range(0, 4);
                if (gap > 0) begin
                    s_axis_tvalid <= 1'b0;
                    s_axis_tdata  <= $urandom();
                    valid_dropped  = 1'b1;
                    repeat (gap) @(posedge i_clk);
                end
            end else begin
                burst_left--;
            end
        end
    endtask

    function automatic logic [DATA_W-1:0] pool_word();
        case ($urandom_range(0, 5))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return 32'h0000_0001;
            default: return 32'h0000_0005;
        endcase
    endfunction

    task automatic test_empty_queue();
        send_item(OP_SEARCH, 32'h0000_0000, 1'b0);
        send_item(OP_DEQUEUE, 32'hFFFF_FFFF, 1'b0);
        send_item(OP_NONE, 32'h5555_5555, 1'b0);
    endtask

    task automatic test_fill_and_overflow();
        logic [DATA_W-1:0] fill_words [16];
        fill_words = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
                       32'h0000_0001, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'hA5A5_A5A5,
                       32'hFFFF_FFFE, 32'h0000_00FF, 32'h1111_1111, 32'hA5A5_A5A5,
                       32'h7FFF_FFFE, 32'h8000_0001, 32'hCAFE_F00D, 32'h1234_5678};
        foreach (fill_words[i]) send_item(OP_ENQUEUE, fill_words[i], 1'b0);
        send_item(OP_ENQUEUE, 32'hDEAD_BEEF, 1'b0);
    endtask

    task automatic test_search_positions();
        send_item(OP_SEARCH, 32'h8000_0000, 1'b0);
        send_item(OP_SEARCH, 32'hA5A5_A5A5, 1'b0);
        send_item(OP_SEARCH, 32'h1234_5678, 1'b0);
        send_item(OP_SEARCH, 32'hDEAD_BEEF, 1'b0);
        send_item(OP_DEQUEUE, 32'h0000_0000, 1'b0);
        send_item(OP_SEARCH, 32'h8000_0000, 1'b0);
    endtask

    // output held off while the sender offers items without gaps
    task automatic test_output_stall();
        t_op op;
        hold_off_req = 1'b1;
        repeat (14) begin
            op = ($urandom_range(0, 1) == 0) ? OP_ENQUEUE : OP_SEARCH;
            send_item(op, pool_word(), 1'b1);
        end
    endtask

    task automatic test_random_traffic(input int n_items);
        int                done_items;
        int                phase;
        int                pick;
        int                enq_lim;
        int                deq_lim;
        int                offset;
        t_op               op;
        logic [DATA_W-1:0] word;
        done_items = 0;
        while (done_items < n_items) begin
            phase = (done_items / 60) % 3;
            case (phase)
                0:       begin enq_lim = 55; deq_lim = 70; end
                1:       begin enq_lim = 15; deq_lim = 60; end
                default: begin enq_lim = 35; deq_lim = 65; end
            endcase
            pick = $urandom_range(0, 99);
            if (pick < enq_lim)      op = OP_ENQUEUE;
            else if (pick < deq_lim) op = OP_DEQUEUE;
            else if (pick < 97)      op = OP_SEARCH;
            else                     op = OP_NONE;
            pick = $urandom_range(0, 99);
            word = $urandom();
            if (op == OP_ENQUEUE && pick < 25) begin
                word = pool_word();
            end else if (op == OP_SEARCH) begin
                if (q_count != 0 && pick < 60) begin
                    offset = $urandom_range(0, int'(q_count) - 1);
                    word   = q_words[(int'(q_head) + offset) % DEPTH];
                end else if (pick < 75) begin
                    word = pool_word();
                end
            end
            send_item(op, word, 1'b0);
            if (op != OP_NONE) done_items++;
        end
    endtask

    initial begin
        int drain_cycles;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_queue();
        test_fill_and_overflow();
        test_search_positions();
        test_output_stall();
        test_random_traffic(860);

        if (!valid_dropped) s_axis_tvalid <= 1'b0;
        drain_cycles = 0;
        while (pending_answers.size() != 0 && drain_cycles < 20000) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        if (pending_answers.size() != 0) begin
            $error("%0d results never arrived", pending_answers.size());
            fail_count++;
        end
        repeat (40) @(posedge i_clk);

        $display("Covered %0d transactions: enqueue %0d, dequeue %0d, search %0d, unused op %0d.",
                 op_tally[0] + op_tally[1] + op_tally[2] + op_tally[3],
                 op_tally[0], op_tally[1], op_tally[2], op_tally[3]);
        $display("Checked %0d results: %0d hits, %0d misses, %0d overflows, %0d underflows.",
                 results_seen, search_hits, search_misses, overflows, underflows);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
